@@ rtl/orfs_pkg.sv @@
`timescale 1ns / 1ps
// Package for the opportunistic RB frame scheduler.
// Holds sizes, codes, the CQI table and the controller/datapath structs; no dependencies.
package orfs_pkg;

   localparam int MAX_USERS   = 8;
   localparam int QUEUE_DEPTH = 16;
   localparam int USER_W      = $clog2(MAX_USERS);
   localparam int SLOT_W      = $clog2(QUEUE_DEPTH);
   localparam int STORE_DEPTH = MAX_USERS * QUEUE_DEPTH;
   localparam int FRAME_RBS_MAX = 100;
   localparam int DIV_STEPS   = 14;

   // Result kinds.
   localparam logic [1:0] KIND_ACCEPT = 2'd0;
   localparam logic [1:0] KIND_DROP   = 2'd1;
   localparam logic [1:0] KIND_GRANT  = 2'd2;

   // Input commands.
   localparam logic CMD_PACKET = 1'b0;
   localparam logic CMD_REPORT = 1'b1;

   // Configuration register indexes.
   localparam logic [1:0] REG_NUM_USERS   = 2'd0;
   localparam logic [1:0] REG_FRAME_RBS   = 2'd1;
   localparam logic [1:0] REG_QUEUE_LIMIT = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take_input;
      logic select;
      logic mul;
      logic pop;
      logic div_init;
      logic div_step;
      logic grant;
      logic emit;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic frame_start;
      logic fill_zero;
      logic fits;
      logic div_done;
      logic round_last;
      logic emit_last;
      logic out_free;
   } ctrl_sts_type;

   // Bytes carried by one resource block at a given CQI.
   function automatic logic [6:0] rb_bytes(input logic [3:0] cqi);
      logic [6:0] b;
      case (cqi)
         4'd0:    b = 7'd0;
         4'd1:    b = 7'd3;
         4'd2:    b = 7'd3;
         4'd3:    b = 7'd6;
         4'd4:    b = 7'd11;
         4'd5:    b = 7'd15;
         4'd6:    b = 7'd20;
         4'd7:    b = 7'd25;
         4'd8:    b = 7'd36;
         4'd9:    b = 7'd39;
         4'd10:   b = 7'd50;
         4'd11:   b = 7'd63;
         4'd12:   b = 7'd72;
         4'd13:   b = 7'd80;
         default: b = 7'd93;
      endcase
      return b;
   endfunction

endpackage

@@ rtl/orfs_if.sv @@
`timescale 1ns / 1ps
// Channel interfaces of the scheduler: input items, results and register writes.
// Depends on nothing.
interface orfs_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [2:0] user;
   logic [9:0] packet_size;
   logic [3:0] cqi;
   modport source (output valid, command, user, packet_size, cqi, input ready);
   modport sink (input valid, command, user, packet_size, cqi, output ready);
endinterface

interface orfs_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [2:0]  grant_user;
   logic [6:0]  used_rbs;
   logic [13:0] used_bytes;
   logic [4:0]  packets_sent;
   logic [13:0] frame_bytes;
   logic [7:0]  backlog;
   logic [15:0] lost_count;
   logic        last;
   modport source (output valid, kind, grant_user, used_rbs, used_bytes, packets_sent,
                   frame_bytes, backlog, lost_count, last, input ready);
   modport sink (input valid, kind, grant_user, used_rbs, used_bytes, packets_sent,
                 frame_bytes, backlog, lost_count, last, output ready);
endinterface

interface orfs_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [6:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/orfs_ram.sv @@
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module orfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

@@ rtl/orfs_ctrl.sv @@
`timescale 1ns / 1ps
// Controller of the scheduler: sequences arrivals, frame building, division and result output.
// Depends on orfs_pkg.
module orfs_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  orfs_pkg::ctrl_sts_type sts,
   output orfs_pkg::ctrl_cmd_type cmd
);
   import orfs_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE    = 9'b000000001,
      ST_SELECT  = 9'b000000010,
      ST_MUL     = 9'b000000100,
      ST_FETCH   = 9'b000001000,
      ST_CHECK   = 9'b000010000,
      ST_DIVINIT = 9'b000100000,
      ST_DIVIDE  = 9'b001000000,
      ST_GRANT   = 9'b010000000,
      ST_EMIT    = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.take_input = 1'b1;
            if (sts.frame_start) begin
               state_in = ST_SELECT;
            end
         end
         ST_SELECT: begin
            cmd.select = 1'b1;
            state_in   = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_FETCH;
         end
         ST_FETCH: begin
            state_in = sts.fill_zero ? ST_DIVINIT : ST_CHECK;
         end
         ST_CHECK: begin
            if (sts.fits) begin
               cmd.pop  = 1'b1;
               state_in = ST_FETCH;
            end else begin
               state_in = ST_DIVINIT;
            end
         end
         ST_DIVINIT: begin
            cmd.div_init = 1'b1;
            state_in     = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (sts.div_done) begin
               state_in = ST_GRANT;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_GRANT: begin
            cmd.grant = 1'b1;
            state_in  = sts.round_last ? ST_EMIT : ST_SELECT;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (sts.emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // A completed report set starts the frame build in the next cycle.
   a_frame_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && sts.frame_start) |=> (state_ff == ST_SELECT))
      else $error("frame start did not enter user selection");

   // The state register always holds exactly one active bit.
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state register is not one-hot");

   // A finished division always leads to the grant of the round.
   a_div_to_grant: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE && sts.div_done) |=> (state_ff == ST_GRANT))
      else $error("finished division did not record a grant");
endmodule

@@ rtl/orfs_dp.sv @@
`timescale 1ns / 1ps
// Datapath of the scheduler: registers, user queues, selection, budget, divider and results.
// Depends on orfs_pkg, orfs_if and orfs_ram.
module orfs_dp (
   input  logic                   clock,
   input  logic                   reset,
   orfs_req_if.sink               req,
   orfs_rsp_if.source             rsp,
   orfs_csr_if.sink               csr,
   input  orfs_pkg::ctrl_cmd_type cmd,
   output orfs_pkg::ctrl_sts_type sts
);
   import orfs_pkg::*;

   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  grant_user;
      logic [6:0]  used_rbs;
      logic [13:0] used_bytes;
      logic [4:0]  packets_sent;
      logic [13:0] frame_bytes;
      logic [7:0]  backlog;
      logic [15:0] lost_count;
      logic        last;
   } rsp_payload_type;

   // Configuration.
   logic [3:0]  num_users_ff, num_users_in;
   logic [6:0]  frame_rbs_ff, frame_rbs_in;
   logic [4:0]  queue_limit_ff, queue_limit_in;
   // Per-user queue state.
   logic [SLOT_W-1:0] head_ff [MAX_USERS];
   logic [SLOT_W-1:0] head_in [MAX_USERS];
   logic [SLOT_W:0]   fill_ff [MAX_USERS];
   logic [SLOT_W:0]   fill_in [MAX_USERS];
   logic [3:0]        qual_ff [MAX_USERS];
   logic [3:0]        qual_in [MAX_USERS];
   logic [3:0]  seen_ff, seen_in;
   logic [7:0]  backlog_ff, backlog_in;
   logic [15:0] lost_ff, lost_in;
   // Frame build.
   logic [MAX_USERS-1:0] served_ff, served_in;
   logic [USER_W:0]   round_ff, round_in;
   logic [USER_W-1:0] emit_ff, emit_in;
   logic [USER_W-1:0] cur_ff, cur_in;
   logic [6:0]  dim_ff, dim_in;
   logic [6:0]  remain_ff, remain_in;
   logic [13:0] budget_ff, budget_in;
   logic [13:0] sent_ff, sent_in;
   logic [4:0]  pkts_ff, pkts_in;
   logic [13:0] total_ff, total_in;
   // Divider.
   logic [13:0] div_num_ff, div_num_in;
   logic [6:0]  div_rem_ff, div_rem_in;
   logic [13:0] div_quo_ff, div_quo_in;
   logic [3:0]  div_cnt_ff, div_cnt_in;
   // Grant buffer.
   logic [USER_W-1:0] g_user_ff  [MAX_USERS];
   logic [USER_W-1:0] g_user_in  [MAX_USERS];
   logic [6:0]        g_rbs_ff   [MAX_USERS];
   logic [6:0]        g_rbs_in   [MAX_USERS];
   logic [13:0]       g_bytes_ff [MAX_USERS];
   logic [13:0]       g_bytes_in [MAX_USERS];
   logic [4:0]        g_pkts_ff  [MAX_USERS];
   logic [4:0]        g_pkts_in  [MAX_USERS];
   logic [13:0]       g_total_ff [MAX_USERS];
   logic [13:0]       g_total_in [MAX_USERS];
   // Output register.
   rsp_payload_type out_ff, out_in;
   logic            out_valid_ff, out_valid_in;

   logic [3:0]        n_users;
   logic [4:0]        lim;
   logic [6:0]        rbs_start;
   logic              out_free;
   logic              req_fire;
   logic              arrival_ok;
   logic [SLOT_W-1:0] wr_slot;
   logic [9:0]        rd_data;
   logic [3:0]        seen_next;
   logic              frame_done;
   logic [USER_W-1:0] best;
   logic              best_found;
   logic [7:0]        rem_sh;
   logic [6:0]        rbs_grant;

   // Clamped configuration.
   always_comb begin
      if (num_users_ff == 4'd0) begin
         n_users = 4'd1;
      end else if (num_users_ff > 4'(MAX_USERS)) begin
         n_users = 4'(MAX_USERS);
      end else begin
         n_users = num_users_ff;
      end
      if (queue_limit_ff == 5'd0) begin
         lim = 5'd1;
      end else if (queue_limit_ff > 5'(QUEUE_DEPTH)) begin
         lim = 5'(QUEUE_DEPTH);
      end else begin
         lim = queue_limit_ff;
      end
      rbs_start = (frame_rbs_ff > 7'(FRAME_RBS_MAX)) ? 7'(FRAME_RBS_MAX) : frame_rbs_ff;
   end

   assign out_free   = !out_valid_ff || rsp.ready;
   assign req.ready  = cmd.take_input && out_free;
   assign csr.ready  = 1'b1;
   assign req_fire   = req.valid && req.ready;
   assign arrival_ok = fill_ff[req.user] < lim;
   assign wr_slot    = head_ff[req.user] + fill_ff[req.user][SLOT_W-1:0];
   assign seen_next  = seen_ff + 4'd1;
   assign frame_done = req_fire && req.command == CMD_REPORT && seen_next >= n_users;

   // Highest quality among unserved frame users; the lower index wins ties.
   always_comb begin
      best       = '0;
      best_found = 1'b0;
      for (int i = 0; i < MAX_USERS; i++) begin
         if (i < int'(n_users) && !served_ff[i]) begin
            if (!best_found || qual_ff[i] > qual_ff[best]) begin
               best = USER_W'(i);
            end
            best_found = 1'b1;
         end
      end
   end

   // One restoring division step and the clamped RB count.
   assign rem_sh    = {div_rem_ff, div_num_ff[13]};
   assign rbs_grant = (div_quo_ff > 14'(remain_ff)) ? remain_ff : div_quo_ff[6:0];

   // Queue memory: one row of slots per user.
   orfs_ram #(
      .WIDTH(10),
      .DEPTH(STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (req_fire && req.command == CMD_PACKET && arrival_ok),
      .wr_addr ({req.user, wr_slot}),
      .wr_data (req.packet_size),
      .rd_addr ({cur_ff, head_ff[cur_ff]}),
      .rd_data (rd_data)
   );

   // Next-state logic for all datapath registers.
   always_comb begin
      num_users_in   = num_users_ff;
      frame_rbs_in   = frame_rbs_ff;
      queue_limit_in = queue_limit_ff;
      head_in   = head_ff;
      fill_in   = fill_ff;
      qual_in   = qual_ff;
      seen_in   = seen_ff;
      backlog_in = backlog_ff;
      lost_in   = lost_ff;
      served_in = served_ff;
      round_in  = round_ff;
      emit_in   = emit_ff;
      cur_in    = cur_ff;
      dim_in    = dim_ff;
      remain_in = remain_ff;
      budget_in = budget_ff;
      sent_in   = sent_ff;
      pkts_in   = pkts_ff;
      total_in  = total_ff;
      div_num_in = div_num_ff;
      div_rem_in = div_rem_ff;
      div_quo_in = div_quo_ff;
      div_cnt_in = div_cnt_ff;
      g_user_in  = g_user_ff;
      g_rbs_in   = g_rbs_ff;
      g_bytes_in = g_bytes_ff;
      g_pkts_in  = g_pkts_ff;
      g_total_in = g_total_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp.ready;

      // Register writes; an index past the list is ignored.
      if (csr.valid) begin
         case (csr.index)
            REG_NUM_USERS:   num_users_in   = csr.data[3:0];
            REG_FRAME_RBS:   frame_rbs_in   = csr.data;
            REG_QUEUE_LIMIT: queue_limit_in = csr.data[4:0];
            default: ;
         endcase
      end

      // Packet arrivals and CQI reports.
      if (req_fire) begin
         if (req.command == CMD_PACKET) begin
            out_in         = '0;
            out_in.grant_user = req.user;
            out_in.last    = 1'b1;
            if (arrival_ok) begin
               fill_in[req.user] = fill_ff[req.user] + 1'b1;
               backlog_in     = backlog_ff + 8'd1;
               out_in.kind    = KIND_ACCEPT;
               out_in.backlog = backlog_ff + 8'd1;
               out_in.lost_count = lost_ff;
            end else begin
               lost_in        = (lost_ff != 16'hFFFF) ? lost_ff + 16'd1 : lost_ff;
               out_in.kind    = KIND_DROP;
               out_in.backlog = backlog_ff;
               out_in.lost_count = (lost_ff != 16'hFFFF) ? lost_ff + 16'd1 : lost_ff;
            end
            out_valid_in = 1'b1;
         end else begin
            qual_in[req.user] = req.cqi;
            seen_in = frame_done ? 4'd0 : seen_next;
         end
      end

      // Frame start.
      if (frame_done) begin
         served_in = '0;
         round_in  = '0;
         emit_in   = '0;
         remain_in = rbs_start;
         total_in  = '0;
      end

      // Pick the next user.
      if (cmd.select) begin
         cur_in = best;
         served_in[best] = 1'b1;
         dim_in  = rb_bytes(qual_ff[best]);
         sent_in = '0;
         pkts_in = '0;
      end

      // Byte budget for the rest of the frame.
      if (cmd.mul) begin
         budget_in = 14'(remain_ff * dim_ff);
      end

      // Dequeue the head packet.
      if (cmd.pop) begin
         head_in[cur_ff] = head_ff[cur_ff] + 1'b1;
         fill_in[cur_ff] = fill_ff[cur_ff] - 1'b1;
         if (backlog_ff != 8'd0) begin
            backlog_in = backlog_ff - 8'd1;
         end
         budget_in = budget_ff - 14'(rd_data);
         sent_in   = sent_ff + 14'(rd_data);
         pkts_in   = pkts_ff + 5'd1;
      end

      // Ceiling division of the bytes sent by the RB size.
      if (cmd.div_init) begin
         div_quo_in = '0;
         div_rem_in = '0;
         if (dim_ff == 7'd0) begin
            div_cnt_in = '0;
         end else begin
            div_num_in = sent_ff + 14'(dim_ff) - 14'd1;
            div_cnt_in = 4'(DIV_STEPS);
         end
      end
      if (cmd.div_step) begin
         div_num_in = {div_num_ff[12:0], 1'b0};
         div_cnt_in = div_cnt_ff - 4'd1;
         if (rem_sh >= {1'b0, dim_ff}) begin
            div_rem_in = 7'(rem_sh - {1'b0, dim_ff});
            div_quo_in = {div_quo_ff[12:0], 1'b1};
         end else begin
            div_rem_in = rem_sh[6:0];
            div_quo_in = {div_quo_ff[12:0], 1'b0};
         end
      end

      // Record the grant of this round.
      if (cmd.grant) begin
         remain_in = remain_ff - rbs_grant;
         total_in  = total_ff + sent_ff;
         g_user_in[round_ff[USER_W-1:0]]  = cur_ff;
         g_rbs_in[round_ff[USER_W-1:0]]   = rbs_grant;
         g_bytes_in[round_ff[USER_W-1:0]] = sent_ff;
         g_pkts_in[round_ff[USER_W-1:0]]  = pkts_ff;
         g_total_in[round_ff[USER_W-1:0]] = total_ff + sent_ff;
         round_in = round_ff + 1'b1;
      end

      // Hand out the buffered grants with the final backlog.
      if (cmd.emit) begin
         out_in.kind         = KIND_GRANT;
         out_in.grant_user   = g_user_ff[emit_ff];
         out_in.used_rbs     = g_rbs_ff[emit_ff];
         out_in.used_bytes   = g_bytes_ff[emit_ff];
         out_in.packets_sent = g_pkts_ff[emit_ff];
         out_in.frame_bytes  = g_total_ff[emit_ff];
         out_in.backlog      = backlog_ff;
         out_in.lost_count   = lost_ff;
         out_in.last         = sts.emit_last;
         out_valid_in        = 1'b1;
         emit_in             = emit_ff + 1'b1;
      end
   end

   // Status to the controller.
   always_comb begin
      sts.frame_start = frame_done;
      sts.fill_zero   = fill_ff[cur_ff] == '0;
      sts.fits        = 14'(rd_data) <= budget_ff;
      sts.div_done    = div_cnt_ff == 4'd0;
      sts.round_last  = (round_ff + 1'b1) == n_users;
      sts.emit_last   = ({1'b0, emit_ff} + 1'b1) == n_users;
      sts.out_free    = out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_users_ff   <= 4'd8;
         frame_rbs_ff   <= 7'd25;
         queue_limit_ff <= 5'd16;
         for (int i = 0; i < MAX_USERS; i++) begin
            head_ff[i] <= '0;
            fill_ff[i] <= '0;
         end
         seen_ff      <= '0;
         backlog_ff   <= '0;
         lost_ff      <= '0;
         served_ff    <= '0;
         round_ff     <= '0;
         emit_ff      <= '0;
         cur_ff       <= '0;
         div_cnt_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         num_users_ff   <= num_users_in;
         frame_rbs_ff   <= frame_rbs_in;
         queue_limit_ff <= queue_limit_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         seen_ff      <= seen_in;
         backlog_ff   <= backlog_in;
         lost_ff      <= lost_in;
         served_ff    <= served_in;
         round_ff     <= round_in;
         emit_ff      <= emit_in;
         cur_ff       <= cur_in;
         div_cnt_ff   <= div_cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      qual_ff    <= qual_in;
      dim_ff     <= dim_in;
      remain_ff  <= remain_in;
      budget_ff  <= budget_in;
      sent_ff    <= sent_in;
      pkts_ff    <= pkts_in;
      total_ff   <= total_in;
      div_num_ff <= div_num_in;
      div_rem_ff <= div_rem_in;
      div_quo_ff <= div_quo_in;
      g_user_ff  <= g_user_in;
      g_rbs_ff   <= g_rbs_in;
      g_bytes_ff <= g_bytes_in;
      g_pkts_ff  <= g_pkts_in;
      g_total_ff <= g_total_in;
      out_ff     <= out_in;
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.kind         = out_ff.kind;
   assign rsp.grant_user   = out_ff.grant_user;
   assign rsp.used_rbs     = out_ff.used_rbs;
   assign rsp.used_bytes   = out_ff.used_bytes;
   assign rsp.packets_sent = out_ff.packets_sent;
   assign rsp.frame_bytes  = out_ff.frame_bytes;
   assign rsp.backlog      = out_ff.backlog;
   assign rsp.lost_count   = out_ff.lost_count;
   assign rsp.last         = out_ff.last;

   // A dequeued packet always fits the remaining budget.
   a_pop_fits: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> 14'(rd_data) <= budget_ff)
      else $error("packet dequeued beyond the byte budget");

   // The bytes sent never need more RBs than the frame has left.
   a_rbs_fit: assert property (@(posedge clock) disable iff (reset)
      (cmd.grant && dim_ff != 7'd0) |-> div_quo_ff <= 14'(remain_ff))
      else $error("RB count exceeds the remaining RBs");

   // The selected user's queue never holds more than its depth.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff[cur_ff] <= (SLOT_W + 1)'(QUEUE_DEPTH))
      else $error("queue fill beyond depth");
endmodule

@@ rtl/opportunistic_rb_frame_scheduler.sv @@
`timescale 1ns / 1ps
// Top level of the opportunistic RB frame scheduler: controller plus datapath.
// Depends on orfs_pkg, orfs_if, orfs_ctrl and orfs_dp.
//
//   channel | direction | payload
//   req     | in        | command, user, packet_size, cqi
//   rsp     | out       | kind, grant_user, used_rbs, used_bytes, packets_sent,
//           |           | frame_bytes, backlog, lost_count, last
//   csr     | in        | index, data (always ready)
//
// A packet arrival or CQI report is taken only while idle; arrivals yield one result.
// A frame serves each user in turn: it sizes the byte budget, dequeues the head packets
// that fit and sizes the grant with the bit-serial RB division; then one grant result
// per user is sent; no input is taken meanwhile.
// Synchronous active-high reset clears queues, counters and the result valid flag.
// A stalled result holds in the output register and holds off new input.
module opportunistic_rb_frame_scheduler (
   input logic        clock,
   input logic        reset,
   orfs_req_if.sink   req,
   orfs_rsp_if.source rsp,
   orfs_csr_if.sink   csr
);
   import orfs_pkg::*;

   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   orfs_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   orfs_dp u_dp (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp),
      .csr   (csr),
      .cmd   (cmd),
      .sts   (sts)
   );
endmodule
